/* src/assert_macros.svh */
// Assertion macros shared by the checker files of the scan core.
// Depends on nothing; expects clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/mbps_pkg.sv */
// Package of the masked byte pattern scan core: constants, item types, helpers.
// Depends on nothing; used by every module of the block.
`default_nettype none

package mbps_pkg;

	localparam int MaxLen  = 16;
	localparam int LenW    = 5;
	localparam int IdxW    = 4;
	localparam int AddrW   = 64;
	localparam int PhaseW  = 12;
	localparam int StepW   = 13;
	localparam int MaxStep = 4096;
	localparam int PaddrW  = 6;
	localparam int DataW   = 64;

	// mask codes per pattern position
	localparam logic [2:0] MASK_ANY   = 3'd0;
	localparam logic [2:0] MASK_EXACT = 3'd1;
	localparam logic [2:0] MASK_LOW   = 3'd2;
	localparam logic [2:0] MASK_HIGH  = 3'd3;

	// register indexes (byte address 8*i)
	localparam logic [2:0] REG_PAT_LO = 3'd0;
	localparam logic [2:0] REG_PAT_HI = 3'd1;
	localparam logic [2:0] REG_MASKS  = 3'd2;
	localparam logic [2:0] REG_LEN    = 3'd3;
	localparam logic [2:0] REG_ALIGN  = 3'd4;

	typedef struct packed {
		logic [7:0]       data_byte;
		logic [AddrW-1:0] byte_address;
		logic             region_first;
		logic             scan_first;
		logic             scan_last;
	} in_item_t;

	typedef struct packed {
		logic             found;
		logic [AddrW-1:0] match_address;
	} out_item_t;

	typedef struct packed {
		logic [63:0]       pattern_low;
		logic [63:0]       pattern_high;
		logic [47:0]       mask_codes;
		logic [LenW-1:0]   pattern_length;
		logic [StepW-1:0]  alignment;
	} cfg_t;

	// what one cell hands to its neighbor
	typedef struct packed {
		logic [7:0] data;
		logic       mark;
		logic       valid;
	} link_t;

	typedef struct packed {
		logic shift;
		logic restart;
	} cell_ctrl_t;

	typedef struct packed {
		logic [7:0] pbyte;
		logic [2:0] code;
		logic       in_use;
	} pat_entry_t;

	function automatic logic pos_ok(input logic [2:0] code, input logic [7:0] p,
			input logic [7:0] b);
		logic r;
		case (code)
			MASK_ANY:   r = 1'b1;
			MASK_EXACT: r = (p == b);
			MASK_LOW:   r = (p[3:0] == b[3:0]);
			MASK_HIGH:  r = (p[7:4] == b[7:4]);
			default:    r = 1'b0;
		endcase
		return r;
	endfunction

	// Pattern position that cell c faces for a pattern of length len:
	// the oldest byte of the window meets pattern position 0.
	function automatic pat_entry_t sel_entry(input logic [LenW-1:0] len,
			input logic [IdxW-1:0] c, input logic [127:0] pat, input logic [47:0] codes);
		pat_entry_t e;
		logic [LenW-1:0] j;
		j        = len - LenW'(1) - {1'b0, c};
		e.in_use = ({1'b0, c} < len);
		e.pbyte  = pat[{j[IdxW-1:0], 3'b000} +: 8];
		e.code   = codes[int'(j[IdxW-1:0]) * 3 +: 3];
		return e;
	endfunction

endpackage

`default_nettype wire

/* src/masked_byte_pattern_scan_core.sv */
// Top level of the masked byte pattern scan core.
// Depends on mbps_pkg, mbps_cell and mbps_regs.
`default_nettype none

// Masked byte pattern scanner. Memory bytes arrive one item per cycle with
// their address and region/scan flags; a row of 16 cells keeps the newest
// bytes of the current region plus a per-byte alignment mark. Each cycle the
// window ending at the newest byte is checked against up to 16 pattern
// positions, each with its own mask code (any, exact, low nibble, high
// nibble, never). The first match of a scan yields one result item carrying
// its start address; a scan that ends without a match yields one not-found
// item (found = 0, address 0). A region start or scan start empties the
// window, so a match never crosses it, and with pattern_length 0 the first
// byte of a region or scan matches at its own address.
// Rate: one input item per cycle while in_ready is high. On acceptance
// the byte shifts into the cell row, and the compare outcome is then
// registered in the output register. A single compare stage sits behind
// the cell row; in_ready falls only while the output register holds an
// untaken result and the item in the compare stage produces another one.
// Configuration: APB-style, 64-bit data, register i at byte address 8*i:
// pattern_low, pattern_high, mask_codes, pattern_length, alignment.
// Write registers only while no item is in flight.

module masked_byte_pattern_scan_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  mbps_pkg::in_item_t            in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output mbps_pkg::out_item_t           out_item,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mbps_pkg::PaddrW-1:0]   paddr,
	input  logic [mbps_pkg::DataW-1:0]    pwdata,
	output logic [mbps_pkg::DataW-1:0]    prdata,
	output logic                          pready
);

	mbps_pkg::cfg_t cfg;

	mbps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// effective length and alignment step after clamping
	logic [mbps_pkg::LenW-1:0]  len_c;
	logic [mbps_pkg::StepW-1:0] step_c;

	always_comb begin
		len_c = (cfg.pattern_length > mbps_pkg::LenW'(mbps_pkg::MaxLen))
			? mbps_pkg::LenW'(mbps_pkg::MaxLen) : cfg.pattern_length;
		if (cfg.alignment == '0) begin
			step_c = mbps_pkg::StepW'(1);
		end else if (cfg.alignment > mbps_pkg::StepW'(mbps_pkg::MaxStep)) begin
			step_c = mbps_pkg::StepW'(mbps_pkg::MaxStep);
		end else begin
			step_c = cfg.alignment;
		end
	end

	// handshake
	logic in_fire;
	logic s1_go;
	logic valid_s1;
	logic restart;

	assign in_fire = in_valid & in_ready;
	assign in_ready = ~valid_s1 | s1_go;
	assign restart = in_item.region_first | in_item.scan_first;

	// alignment phase: region offset modulo step
	logic [mbps_pkg::PhaseW-1:0] phase_q;
	logic [mbps_pkg::PhaseW-1:0] phase_eff;
	logic [mbps_pkg::StepW-1:0]  phase_inc;

	assign phase_eff = restart ? '0 : phase_q;
	assign phase_inc = {1'b0, phase_eff} + mbps_pkg::StepW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (in_fire) begin
			phase_q <= (phase_inc >= step_c) ? '0 : phase_inc[mbps_pkg::PhaseW-1:0];
		end
	end

	// cell row; link[0] is the incoming byte, cell c drives link[c+1]
	mbps_pkg::link_t links [mbps_pkg::MaxLen+1];
	logic [mbps_pkg::MaxLen-1:0] cell_ok;
	logic [mbps_pkg::MaxLen-1:0] cell_valid;
	logic [mbps_pkg::MaxLen-1:0] cell_mark;

	assign links[0].data  = in_item.data_byte;
	assign links[0].mark  = (phase_eff == '0);
	assign links[0].valid = 1'b1;

	for (genvar c = 0; c < mbps_pkg::MaxLen; c++) begin : g_cell
		mbps_pkg::cell_ctrl_t ctrl;
		mbps_pkg::pat_entry_t pat;

		assign ctrl.shift   = in_fire;
		// the newest byte is always kept; older ones die at a restart
		assign ctrl.restart = (c == 0) ? 1'b0 : restart;
		assign pat = mbps_pkg::sel_entry(len_c, mbps_pkg::IdxW'(c),
			{cfg.pattern_high, cfg.pattern_low}, cfg.mask_codes);

		mbps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.link_in  (links[c]),
			.pat      (pat),
			.link_out (links[c+1]),
			.ok       (cell_ok[c])
		);

		assign cell_valid[c] = links[c+1].valid;
		assign cell_mark[c]  = links[c+1].mark;
	end

	// sideband of the item now sitting in the cell row
	logic [mbps_pkg::AddrW-1:0] addr_s1;
	logic                       start_s1;
	logic                       sfirst_s1;
	logic                       slast_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			addr_s1   <= in_item.byte_address;
			start_s1  <= restart;
			sfirst_s1 <= in_item.scan_first;
			slast_s1  <= in_item.scan_last;
		end
	end

	// compare stage
	logic [mbps_pkg::IdxW-1:0]  last_idx;
	logic                       hit;
	logic [mbps_pkg::AddrW-1:0] hit_addr;
	logic                       found_q;
	logic                       found_eff;
	logic                       emit;

	assign last_idx = mbps_pkg::IdxW'(len_c - mbps_pkg::LenW'(1));

	always_comb begin
		if (len_c == '0) begin
			hit      = start_s1;
			hit_addr = addr_s1;
		end else begin
			// window full enough, start offset aligned, every position agrees
			hit      = cell_valid[last_idx] & cell_mark[last_idx] & (&cell_ok);
			hit_addr = addr_s1 - mbps_pkg::AddrW'(last_idx);
		end
	end

	assign found_eff = sfirst_s1 ? 1'b0 : found_q;
	assign emit      = ~found_eff & (hit | slast_s1);
	assign s1_go     = valid_s1 & (~emit | ~out_valid | out_ready);

	// one result per scan: a match or the not-found report closes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (s1_go) begin
			found_q <= found_eff | emit;
		end
	end

	// output register
	mbps_pkg::out_item_t out_q;
	logic                out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go & emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go & emit) begin
			out_q.found         <= hit;
			out_q.match_address <= hit ? hit_addr : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

/* src/mbps_cell.sv */
// One window cell of the scan core: holds a byte, its alignment mark and valid bit.
// Depends on mbps_pkg.
`default_nettype none

module mbps_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mbps_pkg::cell_ctrl_t    ctrl,
	input  mbps_pkg::link_t         link_in,
	input  mbps_pkg::pat_entry_t    pat,
	output mbps_pkg::link_t         link_out,
	output logic                    ok
);

	logic [7:0] data_q;
	logic       mark_q;
	logic       valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q  <= 1'b0;
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			mark_q  <= link_in.mark;
			valid_q <= link_in.valid & ~ctrl.restart;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= link_in.data;
		end
	end

	assign link_out.data  = data_q;
	assign link_out.mark  = mark_q;
	assign link_out.valid = valid_q;

	// unused positions never block a match
	assign ok = ~pat.in_use | mbps_pkg::pos_ok(pat.code, pat.pbyte, data_q);

endmodule

`default_nettype wire

/* src/mbps_regs.sv */
// APB-style configuration registers of the scan core.
// Depends on mbps_pkg.
`default_nettype none

module mbps_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mbps_pkg::PaddrW-1:0]   paddr,
	input  logic [mbps_pkg::DataW-1:0]    pwdata,
	output logic [mbps_pkg::DataW-1:0]    prdata,
	output logic                          pready,
	output mbps_pkg::cfg_t                cfg
);

	mbps_pkg::cfg_t cfg_q;
	logic [2:0]     idx;
	logic           wr;

	assign idx    = paddr[5:3];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_low    <= '0;
			cfg_q.pattern_high   <= '0;
			cfg_q.mask_codes     <= '0;
			cfg_q.pattern_length <= '0;
			cfg_q.alignment      <= mbps_pkg::StepW'(1);
		end else if (wr) begin
			case (idx)
				mbps_pkg::REG_PAT_LO: cfg_q.pattern_low    <= pwdata;
				mbps_pkg::REG_PAT_HI: cfg_q.pattern_high   <= pwdata;
				mbps_pkg::REG_MASKS:  cfg_q.mask_codes     <= pwdata[47:0];
				mbps_pkg::REG_LEN:    cfg_q.pattern_length <= pwdata[mbps_pkg::LenW-1:0];
				mbps_pkg::REG_ALIGN:  cfg_q.alignment      <= pwdata[mbps_pkg::StepW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			mbps_pkg::REG_PAT_LO: prdata = cfg_q.pattern_low;
			mbps_pkg::REG_PAT_HI: prdata = cfg_q.pattern_high;
			mbps_pkg::REG_MASKS:  prdata = {16'd0, cfg_q.mask_codes};
			mbps_pkg::REG_LEN:    prdata = {59'd0, cfg_q.pattern_length};
			mbps_pkg::REG_ALIGN:  prdata = {51'd0, cfg_q.alignment};
			default:              prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* src/mbps_checker.sv */
// Port-level checker for the scan core, bound to the top level.
// Depends on mbps_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mbps_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_ready,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  mbps_pkg::out_item_t           out_item,
	input  logic                          pready
);

	// a not-found item always carries a zero address
	`ASSERT_IMPL(a_nf_zero, out_valid && !out_item.found, out_item.match_address == '0, "not-found item with nonzero address")

	// an untaken result holds
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "result changed while stalled")

	// with the output register empty the input side never stalls
	`ASSERT_IMPL(a_no_stall, !out_valid, in_ready, "input stalled with empty output")

	// configuration port never waits
	`ASSERT_CLK(a_pready, pready, "pready low")

endmodule

bind masked_byte_pattern_scan_core mbps_checker u_chk (.*);

`default_nettype wire
